[sv/tzol_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tzol_pkg
// Shared types and constants of the time zone offset lookup block.
// ---------------------------------------------------------------------------
package tzol_pkg;

    localparam int LEAP_DEPTH       = 32;
    localparam int TRANSITION_DEPTH = 256;
    localparam int TYPE_DEPTH       = 256;

    localparam int LEAP_AW  = (LEAP_DEPTH > 1) ? $clog2(LEAP_DEPTH) : 1;
    localparam int TRANS_AW = (TRANSITION_DEPTH > 1) ? $clog2(TRANSITION_DEPTH) : 1;
    localparam int TYPE_AW  = (TYPE_DEPTH > 1) ? $clog2(TYPE_DEPTH) : 1;
    localparam int LEAP_CW  = $clog2(LEAP_DEPTH + 1);
    localparam int TRANS_CW = $clog2(TRANSITION_DEPTH + 1);

    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        MODE_LOAD_LEAP  = 3'd0,
        MODE_LOAD_TRANS = 3'd1,
        MODE_LOAD_TYPE  = 3'd2,
        MODE_FORWARD    = 3'd3,
        MODE_REVERSE    = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        CFG_USE_FIXED   = 3'd0,
        CFG_FIXED_OFFS  = 3'd1,
        CFG_LEAP_COUNT  = 3'd2,
        CFG_TRANS_COUNT = 3'd3,
        CFG_TYPE_COUNT  = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEAP_ISSUE,
        S_LEAP_EVAL,
        S_ZONE_START,
        S_TR_ISSUE,
        S_TR_EVAL,
        S_TY_ISSUE,
        S_TY_EVAL,
        S_REV_EVAL,
        S_FINISH
    } t_state;

endpackage : tzol_pkg
`default_nettype wire

[sv/timezone_offset_lookup_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// timezone_offset_lookup_core
// Leap-second and time zone offset lookup over three loaded tables.
// ---------------------------------------------------------------------------
// Input words arrive on the slave stream; tuser carries the mode. Load words
// (leap, transition, type) write one table slot in the cycle they are taken
// and give no result; a load to a slot beyond its table is dropped. Forward
// and reverse queries each give one output word on the master stream.
// Tables are written only through loads; a query must not read a slot that
// was never loaded. The count registers come through the config write port.
// Each step of a query waits on a registered read of a table RAM; the
// reverse scan reads the transition and then the type RAM for every
// entry. Only one query is in flight at a time.
// A finished result sits in the output register; if the receiver stalls,
// the core holds in its final state until that register frees up, while
// loads are still accepted when the core is idle. Reset clears the control
// state and configuration registers; table contents are not cleared.
// ---------------------------------------------------------------------------
module timezone_offset_lookup_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // tdata: entry_index[7:0], entry_time[39:8], entry_leap_sum[55:40],
    //        entry_type[63:56], entry_offset[95:64], query_time[159:96]
    input  wire logic [tzol_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // tuser: mode[2:0]
    input  wire logic [2:0]                        i_s_axis_tuser,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // tdata: leap_offset[15:0], leap_second[32:16], zone_offset[64:33], zero pad
    output logic [tzol_pkg::OUT_DATA_W-1:0]        o_m_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    input  wire logic                              i_cfg_we,
    input  wire logic [tzol_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tzol_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tzol_pkg::*;

    // Input field split.
    logic [7:0]  in_idx;
    logic [31:0] in_time;
    logic [15:0] in_sum;
    logic [7:0]  in_type;
    logic [31:0] in_offs;
    logic [63:0] in_qt;
    t_mode       in_mode;
    logic        in_acc;

    assign in_idx  = i_s_axis_tdata[7:0];
    assign in_time = i_s_axis_tdata[39:8];
    assign in_sum  = i_s_axis_tdata[55:40];
    assign in_type = i_s_axis_tdata[63:56];
    assign in_offs = i_s_axis_tdata[95:64];
    assign in_qt   = i_s_axis_tdata[159:96];
    assign in_mode = t_mode'(i_s_axis_tuser);
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;

    // Configuration registers.
    logic        r_use_fixed;
    logic [31:0] r_fixed;
    logic [5:0]  r_leap_count;
    logic [8:0]  r_trans_count;
    logic [8:0]  r_type_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_fixed   <= 1'b0;
            r_fixed       <= '0;
            r_leap_count  <= '0;
            r_trans_count <= '0;
            r_type_count  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_USE_FIXED:   r_use_fixed   <= i_cfg_data[0];
                CFG_FIXED_OFFS:  r_fixed       <= i_cfg_data;
                CFG_LEAP_COUNT:  r_leap_count  <= i_cfg_data[5:0];
                CFG_TRANS_COUNT: r_trans_count <= i_cfg_data[8:0];
                CFG_TYPE_COUNT:  r_type_count  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    logic [31:0] eff_leaps;
    logic [31:0] eff_trans;
    assign eff_leaps = (32'(r_leap_count) < 32'(LEAP_DEPTH)) ?
                       32'(r_leap_count) : 32'(LEAP_DEPTH);
    assign eff_trans = (32'(r_trans_count) < 32'(TRANSITION_DEPTH)) ?
                       32'(r_trans_count) : 32'(TRANSITION_DEPTH);

    // Control and working registers.
    t_state              r_state, n_state;
    logic                r_rev, n_rev;
    logic [63:0]         r_qt, n_qt;
    logic [LEAP_CW-1:0]  r_i, n_i;
    logic [TRANS_CW-1:0] r_j, n_j;
    logic [15:0]         r_lo, n_lo;
    logic [16:0]         r_ls, n_ls;
    logic [31:0]         r_zo, n_zo;
    logic [7:0]          r_sel_type, n_sel_type;
    logic [31:0]         r_tr_time, n_tr_time;
    logic                r_ovalid, n_ovalid;
    logic [64:0]         r_out, n_out;

    // Table RAMs.
    logic [47:0] leap_rdata;
    logic [39:0] tr_rdata;
    logic [31:0] ty_rdata;
    logic [7:0]  ty_raddr;

    tzol_ram #(.WIDTH(48), .DEPTH(LEAP_DEPTH)) u_leap_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && in_mode == MODE_LOAD_LEAP && 32'(in_idx) < 32'(LEAP_DEPTH)),
        .i_waddr (in_idx[LEAP_AW-1:0]),
        .i_wdata ({in_sum, in_time}),
        .i_raddr (r_i[LEAP_AW-1:0]),
        .o_rdata (leap_rdata)
    );

    tzol_ram #(.WIDTH(40), .DEPTH(TRANSITION_DEPTH)) u_trans_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && in_mode == MODE_LOAD_TRANS &&
                  32'(in_idx) < 32'(TRANSITION_DEPTH)),
        .i_waddr (in_idx[TRANS_AW-1:0]),
        .i_wdata ({in_type, in_time}),
        .i_raddr (r_j[TRANS_AW-1:0]),
        .o_rdata (tr_rdata)
    );

    // The reverse scan looks up the type of the entry just read.
    assign ty_raddr = (r_state == S_TR_EVAL) ? tr_rdata[39:32] : r_sel_type;

    tzol_ram #(.WIDTH(32), .DEPTH(TYPE_DEPTH)) u_type_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && in_mode == MODE_LOAD_TYPE && 32'(in_idx) < 32'(TYPE_DEPTH)),
        .i_waddr (in_idx[TYPE_AW-1:0]),
        .i_wdata (in_offs),
        .i_raddr (ty_raddr[TYPE_AW-1:0]),
        .o_rdata (ty_rdata)
    );

    // Datapath terms.
    logic [63:0] base64, sum64, key64, key1, tt64, off64, lo64, ls64, rev_sum;
    logic [31:0] type_off;
    logic        type_ok;

    assign base64   = {{32{leap_rdata[31]}}, leap_rdata[31:0]};
    assign sum64    = {{48{leap_rdata[47]}}, leap_rdata[47:32]};
    assign key64    = base64 + sum64;
    assign key1     = key64 + 64'd1;
    assign type_ok  = ({1'b0, r_sel_type} < r_type_count) &&
                      (32'(r_sel_type) < 32'(TYPE_DEPTH));
    assign type_off = type_ok ? ty_rdata : 32'd0;
    assign tt64     = {{32{r_tr_time[31]}}, r_tr_time};
    assign off64    = {{32{type_off[31]}}, type_off};
    assign lo64     = {{48{r_lo[15]}}, r_lo};
    assign ls64     = {{47{r_ls[16]}}, r_ls};
    assign rev_sum  = tt64 + off64 + lo64 + ls64;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_rev      <= n_rev;
        r_qt       <= n_qt;
        r_i        <= n_i;
        r_j        <= n_j;
        r_lo       <= n_lo;
        r_ls       <= n_ls;
        r_zo       <= n_zo;
        r_sel_type <= n_sel_type;
        r_tr_time  <= n_tr_time;
        r_out      <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_rev      = r_rev;
        n_qt       = r_qt;
        n_i        = r_i;
        n_j        = r_j;
        n_lo       = r_lo;
        n_ls       = r_ls;
        n_zo       = r_zo;
        n_sel_type = r_sel_type;
        n_tr_time  = r_tr_time;
        n_out      = r_out;
        n_ovalid   = r_ovalid && !i_m_axis_tready;
        o_s_axis_tready = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (in_mode == MODE_FORWARD || in_mode == MODE_REVERSE)) begin
                    n_rev   = (in_mode == MODE_REVERSE);
                    n_qt    = in_qt;
                    n_i     = '0;
                    n_lo    = '0;
                    n_ls    = '0;
                    n_state = S_LEAP_ISSUE;
                end
            end
            S_LEAP_ISSUE: begin
                n_state = (32'(r_i) < eff_leaps) ? S_LEAP_EVAL : S_ZONE_START;
            end
            S_LEAP_EVAL: begin
                n_state = S_ZONE_START;
                if (!r_rev) begin
                    if ($signed(base64) < $signed(r_qt)) begin
                        n_lo    = leap_rdata[47:32];
                        n_i     = r_i + 1'b1;
                        n_state = S_LEAP_ISSUE;
                    end else if (base64 == r_qt) begin
                        n_ls = {leap_rdata[47], leap_rdata[47:32]} - {r_lo[15], r_lo};
                    end
                end else begin
                    if ($signed(key1) < $signed(r_qt)) begin
                        n_lo    = leap_rdata[47:32];
                        n_i     = r_i + 1'b1;
                        n_state = S_LEAP_ISSUE;
                    end else if (key1 == r_qt) begin
                        n_lo = leap_rdata[47:32];
                        n_ls = 17'd1;
                    end else if (key64 == r_qt) begin
                        n_lo = leap_rdata[47:32];
                    end
                end
            end
            S_ZONE_START: begin
                n_j        = '0;
                n_zo       = '0;
                n_sel_type = '0;
                if (r_use_fixed) begin
                    n_zo    = r_fixed;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_TR_ISSUE;
                end
            end
            S_TR_ISSUE: begin
                if (32'(r_j) < eff_trans) begin
                    n_state = S_TR_EVAL;
                end else begin
                    n_state = r_rev ? S_FINISH : S_TY_ISSUE;
                end
            end
            S_TR_EVAL: begin
                n_tr_time = tr_rdata[31:0];
                if (r_rev) begin
                    n_sel_type = tr_rdata[39:32];
                    n_state    = S_REV_EVAL;
                end else begin
                    // The type of the last entry before the query time, or of
                    // entry zero when even that one is not before it.
                    if (r_j == '0 ||
                        $signed({{32{tr_rdata[31]}}, tr_rdata[31:0]}) < $signed(r_qt)) begin
                        n_sel_type = tr_rdata[39:32];
                    end
                    if ($signed({{32{tr_rdata[31]}}, tr_rdata[31:0]}) < $signed(r_qt)) begin
                        n_j     = r_j + 1'b1;
                        n_state = S_TR_ISSUE;
                    end else begin
                        n_state = S_TY_ISSUE;
                    end
                end
            end
            S_TY_ISSUE: begin
                n_state = S_TY_EVAL;
            end
            S_TY_EVAL: begin
                n_zo    = type_off;
                n_state = S_FINISH;
            end
            S_REV_EVAL: begin
                if ($signed(rev_sum) < $signed(r_qt)) begin
                    n_zo    = type_off;
                    n_j     = r_j + 1'b1;
                    n_state = S_TR_ISSUE;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_out    = {r_zo, r_ls, r_lo};
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - 65){1'b0}}, r_out};

    a_leap_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_i) <= 32'(LEAP_DEPTH))
        else $error("leap scan index beyond table depth");

    a_trans_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_j) <= 32'(TRANSITION_DEPTH))
        else $error("transition scan index beyond table depth");

    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (in_mode == MODE_FORWARD || in_mode == MODE_REVERSE))
        |=> (r_state == S_LEAP_ISSUE))
        else $error("accepted query did not start the leap scan");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_FINISH))
        else $error("result word raised outside the finish step");

endmodule : timezone_offset_lookup_core
`default_nettype wire

[sv/tzol_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tzol_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tzol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : tzol_ram
`default_nettype wire

[bench/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the leap-second and time zone offset lookup core.
// ---------------------------------------------------------------------------
// A short directed table comes first. It covers queries after reset, extreme
// query times, unused modes and loads to slots beyond a table. Then all table
// slots are loaded, so no later query reads an unwritten slot. Then come
// phases of random traffic, each under its own register setting. Every
// query's answer is checked, the directed ones against zero and the others
// against the in-bench lookup model, with random gaps and stalls on both streams.
// ---------------------------------------------------------------------------
module tb_top;
    import tzol_pkg::*;

    localparam int  LIMIT_CYCLES = 4000000;
    localparam int  LONG_HOLD    = 2000;
    localparam int  SETTLE       = 40;

    typedef struct packed {
        logic signed [31:0] zone;
        logic signed [16:0] lsec;
        logic signed [15:0] loff;
    } zone_result_t;

    typedef struct {
        t_mode              mode;
        logic [7:0]         idx;
        logic signed [31:0] etime;
        logic signed [15:0] esum;
        logic [7:0]         etype;
        logic signed [31:0] eoff;
        logic signed [63:0] qtime;
        bit                 typed;
        zone_result_t       want;
    } stim_row_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic [IN_DATA_W-1:0]    s_tdata;
    logic [2:0]              s_tuser;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    timezone_offset_lookup_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // Shadow copy of the tables and registers.
    logic signed [31:0] leap_base [LEAP_DEPTH];
    logic signed [15:0] leap_sum  [LEAP_DEPTH];
    logic signed [31:0] tr_time   [TRANSITION_DEPTH];
    logic [7:0]         tr_type   [TRANSITION_DEPTH];
    logic signed [31:0] ty_offset [TYPE_DEPTH];
    logic               fixed_mode;
    logic signed [31:0] fixed_value;
    logic [5:0]         leap_cnt;
    logic [8:0]         tr_cnt;
    logic [8:0]         ty_cnt;

    zone_result_t pending_answers[$];
    stim_row_t    dir_rows[$];
    int  mismatches;
    int  answers_seen;
    int  queries_sent;
    int  cycle_count;
    bit  no_idle;
    bit  hold_request;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, pending_answers.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------- lookup model ----------------
    function automatic int leaps_used();
        return (leap_cnt < LEAP_DEPTH) ? int'(leap_cnt) : LEAP_DEPTH;
    endfunction

    function automatic int trans_used();
        return (tr_cnt < TRANSITION_DEPTH) ? int'(tr_cnt) : TRANSITION_DEPTH;
    endfunction

    function automatic longint trans_time_at(int i);
        return (i < trans_used()) ? longint'(tr_time[i]) : 64'sd0;
    endfunction

    function automatic int trans_type_at(int i);
        return (i < trans_used()) ? int'(tr_type[i]) : 0;
    endfunction

    function automatic longint zone_offset_of(int i);
        if (i >= int'(ty_cnt) || i >= TYPE_DEPTH) return 64'sd0;
        return longint'(ty_offset[i]);
    endfunction

    function automatic zone_result_t lookup_forward(longint ts);
        zone_result_t r;
        longint lo, ls;
        int i;
        lo = 0;
        ls = 0;
        for (i = 0; i < leaps_used(); i++) begin
            if (longint'(leap_base[i]) < ts) begin
                lo = longint'(leap_sum[i]);
            end else begin
                if (longint'(leap_base[i]) == ts) ls = longint'(leap_sum[i]) - lo;
                break;
            end
        end
        r.loff = lo[15:0];
        r.lsec = ls[16:0];
        if (fixed_mode) begin
            r.zone = fixed_value;
        end else begin
            for (i = 0; i < trans_used(); i++)
                if (trans_time_at(i) >= ts) break;
            r.zone = 32'(zone_offset_of(trans_type_at(i > 0 ? i - 1 : 0)));
        end
        return r;
    endfunction

    function automatic zone_result_t lookup_reverse(longint ts);
        zone_result_t r;
        longint loff, lsec, zoff, key, off;
        int i;
        loff = 0;
        lsec = 0;
        zoff = 0;
        for (i = 0; i < leaps_used(); i++) begin
            key = longint'(leap_base[i]) + longint'(leap_sum[i]);
            if (key + 1 < ts) begin
                loff = longint'(leap_sum[i]);
            end else if (key + 1 == ts) begin
                loff = longint'(leap_sum[i]);
                lsec = 1;
                break;
            end else begin
                if (key == ts) loff = longint'(leap_sum[i]);
                break;
            end
        end
        if (fixed_mode) begin
            zoff = longint'(fixed_value);
        end else begin
            for (i = 0; i < trans_used(); i++) begin
                off = zone_offset_of(trans_type_at(i));
                if (trans_time_at(i) + off + loff + lsec < ts) zoff = off;
                else break;
            end
        end
        r.loff = loff[15:0];
        r.lsec = lsec[16:0];
        r.zone = zoff[31:0];
        return r;
    endfunction

    // ---------------- stream driver ----------------
    task automatic offer(input stim_row_t row);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.mode;
        s_tdata  <= {row.qtime, row.eoff, row.etype, row.esum, row.etime, row.idx};
        do @(posedge i_clk); while (!s_tready);
        case (row.mode)
            MODE_LOAD_LEAP: if (row.idx < LEAP_DEPTH) begin
                leap_base[row.idx] = row.etime;
                leap_sum[row.idx]  = row.esum;
            end
            MODE_LOAD_TRANS: begin
                tr_time[row.idx] = row.etime;
                tr_type[row.idx] = row.etype;
            end
            MODE_LOAD_TYPE: ty_offset[row.idx] = row.eoff;
            MODE_FORWARD, MODE_REVERSE: begin
                queries_sent++;
                if (row.typed) pending_answers.push_back(row.want);
                else if (row.mode == MODE_FORWARD)
                    pending_answers.push_back(lookup_forward(row.qtime));
                else pending_answers.push_back(lookup_reverse(row.qtime));
            end
            default: ;
        endcase
    endtask

    function automatic stim_row_t blank_row(t_mode m);
        stim_row_t row;
        row.mode  = m;
        row.idx   = 8'($urandom());
        row.etime = $urandom();
        row.esum  = 16'($urandom());
        row.etype = 8'($urandom());
        row.eoff  = $urandom();
        row.qtime = {$urandom(), $urandom()};
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic stim_row_t zero_answer(t_mode m, logic signed [63:0] q);
        stim_row_t row;
        row       = blank_row(m);
        row.qtime = q;
        row.typed = 1'b1;
        return row;
    endfunction

    // Query times cluster on table entries so the scans stop at every position.
    function automatic logic signed [63:0] pick_query_time(bit reverse);
        int  sel, k;
        longint t;
        sel = $urandom_range(0, 99);
        k   = $urandom_range(0, 31);
        if (sel < 30) begin
            t = longint'(leap_base[k]) + (reverse ? longint'(leap_sum[k]) : 0);
        end else if (sel < 60) begin
            k = $urandom_range(0, (trans_used() > 0) ? trans_used() - 1 : 0);
            t = longint'(tr_time[k]);
            if (reverse) t += longint'(ty_offset[tr_type[k]]);
        end else if (sel < 80) begin
            return {{32{1'b0}}, 32'($urandom())} - 64'sh8000_0000;
        end else if (sel < 88) begin
            case ($urandom_range(0, 3))
                0: return 64'sh8000_0000_0000_0000;
                1: return 64'sh7fff_ffff_ffff_ffff;
                2: return 64'sh7fff_ffff_ffff_fffe;
                default: return 64'sd0;
            endcase
        end else begin
            return {$urandom(), $urandom()};
        end
        return t + $urandom_range(0, 4) - 2;
    endfunction

    task automatic write_registers(input logic fixed, input logic signed [31:0] value,
                                   input logic [5:0] lc, input logic [8:0] tc,
                                   input logic [8:0] yc);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_USE_FIXED;
        cfg_data  <= {31'd0, fixed};
        @(posedge i_clk);
        cfg_index <= CFG_FIXED_OFFS;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_index <= CFG_LEAP_COUNT;
        cfg_data  <= {26'd0, lc};
        @(posedge i_clk);
        cfg_index <= CFG_TRANS_COUNT;
        cfg_data  <= {23'd0, tc};
        @(posedge i_clk);
        cfg_index <= CFG_TYPE_COUNT;
        cfg_data  <= {23'd0, yc};
        @(posedge i_clk);
        cfg_we      <= 1'b0;
        fixed_mode  = fixed;
        fixed_value = value;
        leap_cnt    = lc;
        tr_cnt      = tc;
        ty_cnt      = yc;
    endtask

    // Registers change only once every answer is back and the core has settled.
    // The last word is withdrawn first so the core cannot take it twice.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Rewrite the head of the leap and transition tables in ascending order.
    task automatic load_sorted(input int nleap, input int ntrans);
        stim_row_t row;
        int i;
        longint t;
        t = -64'sd2000000000 + $urandom_range(0, 1000);
        for (i = 0; i < nleap; i++) begin
            row       = blank_row(MODE_LOAD_LEAP);
            row.idx   = 8'(i);
            t        += $urandom_range(1, 5000000);
            row.etime = t[31:0];
            row.esum  = 16'(i + 10 + int'($urandom_range(0, 1)));
            offer(row);
        end
        t = -64'sd1000000000;
        for (i = 0; i < ntrans; i++) begin
            row       = blank_row(MODE_LOAD_TRANS);
            row.idx   = 8'(i);
            t        += $urandom_range(1, 8000000);
            row.etime = t[31:0];
            row.etype = 8'($urandom_range(0, 7));
            offer(row);
        end
    endtask

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        zone_result_t got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = {m_tdata[64:33], m_tdata[32:16], m_tdata[15:0]};
            answers_seen++;
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected answer word %h at cycle %0d", got, cycle_count);
            end else begin
                want = pending_answers.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Answer %0d: leap_offset %0d/%0d leap_second %0d/%0d zone %0d/%0d (want/got)",
                                 answers_seen, want.loff, got.loff, want.lsec, got.lsec,
                                 want.zone, got.zone);
                end
            end
        end
    end

    // Receiver: random stalls, a no-stall mode, and one long hold when asked.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_request = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        stim_row_t row;
        int i, ph, n, sel, nitems;
        logic [5:0] lc;
        logic [8:0] tc, yc;
        logic fx;
        logic signed [31:0] fv;

        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        mismatches = 0;
        answers_seen = 0;
        queries_sent = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        hold_request = 1'b0;
        fixed_mode = 1'b0;
        fixed_value = '0;
        leap_cnt = '0;
        tr_cnt = '0;
        ty_cnt = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: with all counts zero every answer is zero.
        dir_rows.push_back(zero_answer(MODE_FORWARD, 64'sh8000_0000_0000_0000));
        dir_rows.push_back(zero_answer(MODE_FORWARD, 64'sh7fff_ffff_ffff_ffff));
        dir_rows.push_back(zero_answer(MODE_FORWARD, 64'sd0));
        dir_rows.push_back(zero_answer(MODE_REVERSE, 64'sh8000_0000_0000_0000));
        dir_rows.push_back(zero_answer(MODE_REVERSE, 64'sh7fff_ffff_ffff_ffff));
        dir_rows.push_back(zero_answer(MODE_REVERSE, 64'sd1));
        dir_rows.push_back(zero_answer(MODE_REVERSE, -64'sd1));
        for (i = 5; i < 8; i++) dir_rows.push_back(blank_row(t_mode'(i)));
        row = blank_row(MODE_LOAD_LEAP);
        row.idx = 8'd255;
        dir_rows.push_back(row);
        row.idx = 8'(LEAP_DEPTH);
        dir_rows.push_back(row);
        row = blank_row(MODE_LOAD_LEAP);
        row.idx = 8'd0;
        row.etime = 32'sh8000_0000;
        row.esum = 16'sh7fff;
        dir_rows.push_back(row);
        row = blank_row(MODE_LOAD_TRANS);
        row.idx = 8'd255;
        row.etime = 32'sh7fff_ffff;
        row.etype = 8'hff;
        dir_rows.push_back(row);
        row = blank_row(MODE_LOAD_TYPE);
        row.idx = 8'd255;
        row.eoff = 32'sh8000_0000;
        dir_rows.push_back(row);
        row = blank_row(MODE_LOAD_TYPE);
        row.idx = 8'd0;
        row.eoff = 32'sh7fff_ffff;
        dir_rows.push_back(row);
        foreach (dir_rows[k]) offer(dir_rows[k]);

        // Fill every slot of every table, in bursts without idling.
        no_idle = 1'b1;
        for (i = 0; i < LEAP_DEPTH; i++) begin
            row = blank_row(MODE_LOAD_LEAP);
            row.idx = 8'(i);
            offer(row);
        end
        for (i = 0; i < TRANSITION_DEPTH; i++) begin
            row = blank_row(MODE_LOAD_TRANS);
            row.idx = 8'(i);
            offer(row);
            row = blank_row(MODE_LOAD_TYPE);
            row.idx = 8'(i);
            offer(row);
        end
        no_idle = 1'b0;

        for (ph = 0; ph < 12; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    lc = 6'd63; tc = 9'd511; yc = 9'd511; fx = 1'b0; fv = 32'sd0;
                end
                1: begin
                    lc = 6'd0; tc = 9'd0; yc = 9'd0; fx = 1'b0; fv = 32'sh7fff_ffff;
                end
                2: begin
                    lc = 6'd32; tc = 9'd256; yc = 9'd256; fx = 1'b1; fv = 32'sh8000_0000;
                end
                3: begin
                    lc = 6'd5; tc = 9'd3; yc = 9'd8; fx = 1'b1; fv = 32'sh7fff_ffff;
                end
                default: begin
                    lc = 6'($urandom_range(0, 40));
                    tc = ($urandom_range(0, 3) == 0) ? 9'($urandom()) :
                         9'($urandom_range(0, 24));
                    yc = ($urandom_range(0, 1) == 0) ? 9'($urandom_range(0, 511)) : 9'd8;
                    fx = ($urandom_range(0, 3) == 0);
                    fv = $urandom();
                end
            endcase
            write_registers(fx, fv, lc, tc, yc);
            no_idle = (ph == 5 || ph == 9);
            if (ph == 6) hold_request = 1'b1;
            if (ph >= 3 && ph % 2 == 1) load_sorted(32, 24);
            nitems = (ph == 0) ? 9 : 10;
            for (n = 0; n < nitems; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 15) row = blank_row(t_mode'($urandom_range(0, 2)));
                else if (sel < 20) row = blank_row(t_mode'($urandom_range(5, 7)));
                else begin
                    row = blank_row((sel < 60) ? MODE_FORWARD : MODE_REVERSE);
                    row.qtime = pick_query_time(row.mode == MODE_REVERSE);
                end
                offer(row);
            end
        end

        wait_idle();
        repeat (200) @(posedge i_clk);
        $display("Run covered %0d queries under 12 register settings, forward and reverse,",
                 queries_sent);
        $display("with table reloads, unused modes, stalls and a long receiver hold.");
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d answers missing", mismatches,
                     pending_answers.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
